// ===== sv/sacl_pkg.sv =====
// ----------------------------------------------------------------------------
// sacl_pkg - shared types and constants of the LRU cache directory
// Access kinds, register map, the clamped register set and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package sacl_pkg;

   // default geometry
   localparam int MAX_SET_BITS_DEF = 6;
   localparam int MAX_WAYS_DEF     = 8;

   // fixed field widths
   localparam int ADDR_W  = 32;
   localparam int KIND_W  = 3;
   localparam int TAG_W   = 31;
   localparam int STAMP_W = 32;
   localparam int CNT_W   = 32;
   localparam int SETB_W  = 4;    // holds a clamped set-index bit count
   localparam int WAYC_W  = 6;    // holds a clamped way count
   localparam int OFFB_W  = 5;
   localparam int SHIFT_W = 6;    // set bits plus offset bits
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;
   localparam int RSP_W   = 104;

   // access kinds
   localparam logic [KIND_W-1:0] KIND_LOAD   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_STORE  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_MODIFY = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FETCH  = 3'd3;

   // register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_SET_BITS = 2'd0;
   localparam logic [1:0] REG_WAYS     = 2'd1;
   localparam logic [1:0] REG_OFF_BITS = 2'd2;

   // one directory entry
   typedef struct packed {
      logic               valid;
      logic [TAG_W-1:0]   tag;
      logic [STAMP_W-1:0] stamp;
   } line_type;

   // register values after range clamping
   typedef struct packed {
      logic [SETB_W-1:0] set_bits;
      logic [WAYC_W-1:0] ways;
      logic [OFFB_W-1:0] off_bits;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic scan;
      logic update;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_lookup;
      logic last_way;
      logic out_free;
   } stat_type;

endpackage

// ===== sv/sacl_csr.sv =====
// ----------------------------------------------------------------------------
// sacl_csr - configuration registers
// APB-style register file for the cache geometry, with range clamping of the
// values handed to the datapath.
// ----------------------------------------------------------------------------
module sacl_csr #(
   parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
   parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [sacl_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [sacl_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [sacl_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready,
   output sacl_pkg::cfg_type             cfg
);
   import sacl_pkg::*;

   logic [2:0] set_bits_ff, set_bits_in;
   logic [3:0] ways_ff, ways_in;
   logic [4:0] off_bits_ff, off_bits_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   // register write
   always_comb begin
      set_bits_in = set_bits_ff;
      ways_in     = ways_ff;
      off_bits_in = off_bits_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_SET_BITS: set_bits_in = csr_pwdata[2:0];
            REG_WAYS:     ways_in     = csr_pwdata[3:0];
            REG_OFF_BITS: off_bits_in = csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff <= 3'd1;
         ways_ff     <= 4'd1;
         off_bits_ff <= 5'd1;
      end else begin
         set_bits_ff <= set_bits_in;
         ways_ff     <= ways_in;
         off_bits_ff <= off_bits_in;
      end
   end

   // readback
   always_comb begin
      case (reg_idx)
         REG_SET_BITS: csr_prdata = CSR_DW'(set_bits_ff);
         REG_WAYS:     csr_prdata = CSR_DW'(ways_ff);
         REG_OFF_BITS: csr_prdata = CSR_DW'(off_bits_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // clamp to the legal ranges; zero acts as one
   always_comb begin
      if (set_bits_ff == 3'd0)
         cfg.set_bits = SETB_W'(1);
      else if (SETB_W'(set_bits_ff) > SETB_W'(MAX_SET_BITS))
         cfg.set_bits = SETB_W'(MAX_SET_BITS);
      else
         cfg.set_bits = SETB_W'(set_bits_ff);

      if (ways_ff == 4'd0)
         cfg.ways = WAYC_W'(1);
      else if (WAYC_W'(ways_ff) > WAYC_W'(MAX_WAYS))
         cfg.ways = WAYC_W'(MAX_WAYS);
      else
         cfg.ways = WAYC_W'(ways_ff);

      cfg.off_bits = (off_bits_ff == 5'd0) ? 5'd1 : off_bits_ff;
   end

endmodule

// ===== sv/sacl_ctrl.sv =====
// ----------------------------------------------------------------------------
// sacl_ctrl - access sequencer
// Clears the directory after reset, then walks each lookup through way scan,
// write-back and result transfer; other kinds go straight to result transfer.
// ----------------------------------------------------------------------------
module sacl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  sacl_pkg::stat_type st,
   output sacl_pkg::cmd_type  cmd
);
   import sacl_pkg::*;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (st.clear_last) state_in = ST_IDLE;
         ST_IDLE:   if (req_tvalid) state_in = ST_SCAN;
         ST_SCAN: begin
            if (!st.is_lookup)
               state_in = ST_FINISH;
            else if (st.last_way)
               state_in = ST_DRAIN;
         end
         ST_DRAIN:  state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_FINISH;
         ST_FINISH: if (st.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_CLEAR:  cmd.clear = 1'b1;
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_SCAN:   cmd.scan   = st.is_lookup;
         ST_DRAIN:  ;
         ST_UPDATE: cmd.update = 1'b1;
         ST_FINISH: cmd.finish = st.out_free;
         default:   ;
      endcase
   end

endmodule

// ===== sv/sacl_dp.sv =====
// ----------------------------------------------------------------------------
// sacl_dp - directory datapath
// Line memory, address split, way-by-way tag and age search, write-back,
// access clock, running totals and the result register.
// ----------------------------------------------------------------------------
module sacl_dp #(
   parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
   parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sacl_pkg::cfg_type            cfg,
   input  sacl_pkg::cmd_type            cmd,
   output sacl_pkg::stat_type           st,
   input  logic [sacl_pkg::KIND_W-1:0]  req_kind,
   input  logic [sacl_pkg::ADDR_W-1:0]  req_addr,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [sacl_pkg::RSP_W-1:0]   rsp_tdata
);
   import sacl_pkg::*;

   localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int LINE_W = MAX_SET_BITS + WAY_W;
   localparam int DEPTH  = 1 << LINE_W;

   line_type line_mem [DEPTH];
   line_type q_ff;

   logic [LINE_W-1:0]       clr_ptr_ff;
   logic [KIND_W-1:0]       kind_ff;
   logic [TAG_W-1:0]        tag_ff, tag_in;
   logic [MAX_SET_BITS-1:0] set_ff, set_in;
   logic [WAY_W-1:0]        rd_way_ff, eval_way_ff;
   logic                    rd_pend_ff;

   logic                    hit_ff, inv_ff;
   logic [WAY_W-1:0]        hit_way_ff, inv_way_ff, best_way_ff;
   logic [STAMP_W-1:0]      best_age_ff;

   logic [STAMP_W-1:0]      clock_ff;
   logic [CNT_W-1:0]        hit_cnt_ff, miss_cnt_ff, evict_cnt_ff;
   logic                    rsp_valid_ff;
   logic [1:0]              rsp_hits_ff;
   logic                    rsp_miss_ff, rsp_evict_ff;

   logic [SHIFT_W-1:0]      shift;
   logic [ADDR_W-1:0]       set_mask, tag_shifted, set_shifted;
   logic [WAYC_W-1:0]       ways_m1;
   logic [STAMP_W-1:0]      age;
   logic                    is_lookup, is_modify, q_match;
   logic [WAY_W-1:0]        pick_way;
   logic [1:0]              hits;
   logic                    miss, evict;

   // address split under the current geometry
   always_comb begin
      shift       = SHIFT_W'(cfg.set_bits) + SHIFT_W'(cfg.off_bits);
      tag_shifted = req_addr >> shift;
      set_shifted = req_addr >> cfg.off_bits;
      set_mask    = ~({ADDR_W{1'b1}} << cfg.set_bits);
      tag_in      = (shift >= SHIFT_W'(ADDR_W)) ? '0 : tag_shifted[TAG_W-1:0];
      set_in      = set_ff;
      set_in      = MAX_SET_BITS'(set_shifted & set_mask);
   end

   assign is_lookup = (kind_ff == KIND_LOAD) || (kind_ff == KIND_STORE) ||
                      (kind_ff == KIND_MODIFY);
   assign is_modify = (kind_ff == KIND_MODIFY);
   assign ways_m1   = cfg.ways - WAYC_W'(1);

   assign st.clear_last = (clr_ptr_ff == LINE_W'(DEPTH - 1));
   assign st.is_lookup  = is_lookup;
   assign st.last_way   = (WAYC_W'(rd_way_ff) == ways_m1);
   assign st.out_free   = !rsp_valid_ff || rsp_tready;

   // request capture and read pointer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         tag_ff  <= tag_in;
         set_ff  <= set_in;
      end
      eval_way_ff <= rd_way_ff;
      if (cmd.load)
         rd_way_ff <= '0;
      else if (cmd.scan)
         rd_way_ff <= rd_way_ff + WAY_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
         clr_ptr_ff <= '0;
      end else begin
         rd_pend_ff <= cmd.scan;
         if (cmd.clear)
            clr_ptr_ff <= clr_ptr_ff + LINE_W'(1);
      end
   end

   // line memory: one write port, one registered read port
   assign pick_way = hit_ff ? hit_way_ff : (inv_ff ? inv_way_ff : best_way_ff);

   always_ff @(posedge clock) begin
      if (cmd.clear)
         line_mem[clr_ptr_ff] <= '0;
      else if (cmd.update)
         line_mem[{set_ff, pick_way}] <= '{valid: 1'b1, tag: tag_ff, stamp: clock_ff};
      q_ff <= line_mem[{set_ff, rd_way_ff}];
   end

   // search over the way read in the previous cycle
   assign age     = clock_ff - q_ff.stamp;
   assign q_match = q_ff.valid && (q_ff.tag == tag_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hit_ff <= 1'b0;
         inv_ff <= 1'b0;
      end else if (rd_pend_ff) begin
         if (q_match && !hit_ff) begin
            hit_ff     <= 1'b1;
            hit_way_ff <= eval_way_ff;
         end
         if (!q_ff.valid && !inv_ff) begin
            inv_ff     <= 1'b1;
            inv_way_ff <= eval_way_ff;
         end
         // oldest stamp, lowest way on ties
         if ((eval_way_ff == '0) || (age > best_age_ff)) begin
            best_age_ff <= age;
            best_way_ff <= eval_way_ff;
         end
      end
   end

   // outcome of the finished access
   assign hits  = {1'b0, hit_ff} + {1'b0, is_modify};
   assign miss  = is_lookup && !hit_ff;
   assign evict = miss && !inv_ff;

   // access clock, totals and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff     <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         evict_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            if (kind_ff != KIND_FETCH)
               clock_ff <= clock_ff + STAMP_W'(1);
            hit_cnt_ff   <= hit_cnt_ff + CNT_W'(hits);
            miss_cnt_ff  <= miss_cnt_ff + CNT_W'(miss);
            evict_cnt_ff <= evict_cnt_ff + CNT_W'(evict);
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_hits_ff  <= hits;
         rsp_miss_ff  <= miss;
         rsp_evict_ff <= evict;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, evict_cnt_ff, miss_cnt_ff, hit_cnt_ff,
                        rsp_evict_ff, rsp_miss_ff, rsp_hits_ff};

endmodule

// ===== sv/set_assoc_cache_lru_sim.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim - set-associative cache directory, LRU replacement
// Counts hits, misses and evictions of an access stream against a cache
// directory whose set, way and offset split is set through registers.
// ----------------------------------------------------------------------------
// After reset the block sweeps the line memory to mark every line invalid,
// one line per cycle, all 2^(MAX_SET_BITS + clog2(MAX_WAYS)) lines (512 with
// the default geometry); no access is taken during the sweep, register
// writes are. For a load, store or modify the ways in use of the set are
// read from the line memory one per cycle, then a drain state takes the last
// read, an update state writes the chosen line back and a finish state loads
// the result register once the output register is free. Instruction fetches
// and other kinds skip the memory and go from scan to finish. The block then
// returns to idle, where the next transfer in is taken. One access is worked
// on at a time; the next one is taken while the previous result still waits
// in the output register.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_sim #(
   parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
   parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // access stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [31:0]                   req_tdata,   // [31:0] address
   input  logic [7:0]                    req_tuser,   // [2:0] req_type, [7:3] zero
   // result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [1:0] hits_added, [2] was_miss, [3] was_eviction, [35:4] hit_total,
   // [67:36] miss_total, [99:68] eviction_total, [103:100] zero
   output logic [sacl_pkg::RSP_W-1:0]    rsp_tdata,
   // register port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [sacl_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [sacl_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [sacl_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import sacl_pkg::*;

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type st;

   sacl_csr #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sacl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   sacl_dp #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .st         (st),
      .req_kind   (req_tuser[KIND_W-1:0]),
      .req_addr   (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - testbench of the LRU cache directory
// Sends a table of directed accesses and register settings, then random
// phases of accesses under random cache geometries. Every result transfer is
// compared field by field against a cycle-free directory model kept here, or against the result typed into its row.
// ----------------------------------------------------------------------------
module tb_top;
   import sacl_pkg::*;

   // kinds 4..7 only age the lines
   localparam logic [KIND_W-1:0] KIND_OTHER_LO = 3'd4;
   localparam logic [KIND_W-1:0] KIND_OTHER_HI = 3'd7;

   localparam int NUM_WAYS     = MAX_WAYS_DEF;
   localparam int NUM_LINES    = (1 << MAX_SET_BITS_DEF) * MAX_WAYS_DEF;
   localparam int RANDOM_ITEMS = 950;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 50;

   typedef struct packed {
      logic [1:0]       hits;
      logic             miss;
      logic             evict;
      logic [CNT_W-1:0] hit_sum;
      logic [CNT_W-1:0] miss_sum;
      logic [CNT_W-1:0] evict_sum;
   } outcome_type;

   typedef enum logic {ROW_ACCESS, ROW_REG} row_kind_type;

   typedef struct packed {
      row_kind_type      op;
      logic [KIND_W-1:0] kind;
      logic [1:0]        reg_idx;
      logic [31:0]       value;     // address, or register value
      logic              fixed;     // result typed in below
      outcome_type       result;
   } row_type;

   localparam int NUM_ROWS = 31;

   // directed accesses; the first rows run under the reset geometry
   // (two sets, one way, one offset bit), so their results are plain
   row_type directed_rows [NUM_ROWS] = '{
      '{ROW_ACCESS, KIND_LOAD,     REG_SET_BITS, 32'h0000_0000, 1'b1,
        '{2'd0, 1'b1, 1'b0, 32'd0, 32'd1, 32'd0}},
      '{ROW_ACCESS, KIND_LOAD,     REG_SET_BITS, 32'h0000_0000, 1'b1,
        '{2'd1, 1'b0, 1'b0, 32'd1, 32'd1, 32'd0}},
      '{ROW_ACCESS, KIND_MODIFY,   REG_SET_BITS, 32'h0000_0000, 1'b1,
        '{2'd2, 1'b0, 1'b0, 32'd3, 32'd1, 32'd0}},
      '{ROW_ACCESS, KIND_FETCH,    REG_SET_BITS, 32'hFFFF_FFFF, 1'b1,
        '{2'd0, 1'b0, 1'b0, 32'd3, 32'd1, 32'd0}},
      '{ROW_ACCESS, KIND_OTHER_LO, REG_SET_BITS, 32'h0000_0000, 1'b1,
        '{2'd0, 1'b0, 1'b0, 32'd3, 32'd1, 32'd0}},
      '{ROW_ACCESS, KIND_STORE,    REG_SET_BITS, 32'hFFFF_FFFF, 1'b1,
        '{2'd0, 1'b1, 1'b0, 32'd3, 32'd2, 32'd0}},
      '{ROW_ACCESS, KIND_LOAD,     REG_SET_BITS, 32'hFFFF_FFFC, 1'b1,
        '{2'd0, 1'b1, 1'b1, 32'd3, 32'd3, 32'd1}},
      '{ROW_ACCESS, KIND_MODIFY,   REG_SET_BITS, 32'h0000_0000, 1'b1,
        '{2'd1, 1'b1, 1'b1, 32'd4, 32'd4, 32'd2}},
      '{ROW_ACCESS, KIND_OTHER_HI, REG_SET_BITS, 32'h1234_5678, 1'b1,
        '{2'd0, 1'b0, 1'b0, 32'd4, 32'd4, 32'd2}},
      // registers above range: all eight ways, six set bits, tag forced to zero
      '{ROW_REG,    KIND_LOAD,     REG_WAYS,     32'd15,        1'b0, '0},
      '{ROW_REG,    KIND_LOAD,     REG_SET_BITS, 32'd7,         1'b0, '0},
      '{ROW_REG,    KIND_LOAD,     REG_OFF_BITS, 32'd31,        1'b0, '0},
      '{ROW_ACCESS, KIND_LOAD,     REG_SET_BITS, 32'h8000_0000, 1'b0, '0},
      '{ROW_ACCESS, KIND_LOAD,     REG_SET_BITS, 32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_ACCESS, KIND_MODIFY,   REG_SET_BITS, 32'h7FFF_FFFF, 1'b0, '0},
      // registers at zero act as their minimum
      '{ROW_REG,    KIND_LOAD,     REG_OFF_BITS, 32'd0,         1'b0, '0},
      '{ROW_REG,    KIND_LOAD,     REG_SET_BITS, 32'd0,         1'b0, '0},
      '{ROW_REG,    KIND_LOAD,     REG_WAYS,     32'd0,         1'b0, '0},
      '{ROW_ACCESS, KIND_LOAD,     REG_SET_BITS, 32'hAAAA_AAAA, 1'b0, '0},
      '{ROW_ACCESS, KIND_STORE,    REG_SET_BITS, 32'h5555_5555, 1'b0, '0},
      '{ROW_ACCESS, KIND_OTHER_HI, REG_SET_BITS, 32'hFFFF_FFFF, 1'b0, '0},
      // two ways, widest normal split: LRU victim choice
      '{ROW_REG,    KIND_LOAD,     REG_WAYS,     32'd2,         1'b0, '0},
      '{ROW_REG,    KIND_LOAD,     REG_SET_BITS, 32'd6,         1'b0, '0},
      '{ROW_REG,    KIND_LOAD,     REG_OFF_BITS, 32'd24,        1'b0, '0},
      '{ROW_ACCESS, KIND_LOAD,     REG_SET_BITS, 32'h0000_0000, 1'b0, '0},
      '{ROW_ACCESS, KIND_LOAD,     REG_SET_BITS, 32'h4000_0000, 1'b0, '0},
      '{ROW_ACCESS, KIND_LOAD,     REG_SET_BITS, 32'h0000_0000, 1'b0, '0},
      '{ROW_ACCESS, KIND_STORE,    REG_SET_BITS, 32'h8000_0000, 1'b0, '0},
      '{ROW_ACCESS, KIND_MODIFY,   REG_SET_BITS, 32'h4000_0000, 1'b0, '0},
      '{ROW_ACCESS, KIND_FETCH,    REG_SET_BITS, 32'h4000_0000, 1'b0, '0},
      '{ROW_ACCESS, KIND_LOAD,     REG_SET_BITS, 32'h4000_0000, 1'b0, '0}
   };

   // DUT signals; the inputs are all known from time zero
   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [31:0]         req_tdata   = '0;   // [31:0] address
   logic [7:0]          req_tuser   = '0;   // [2:0] req_type, [7:3] zero
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   // [1:0] hits_added, [2] was_miss, [3] was_eviction, [35:4] hit_total,
   // [67:36] miss_total, [99:68] eviction_total, [103:100] zero
   logic [RSP_W-1:0]    rsp_tdata;
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr   = '0;
   logic [CSR_DW-1:0]   csr_pwdata  = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   // directory model state
   logic              line_ok    [NUM_LINES];
   logic [31:0]       line_tagv  [NUM_LINES];
   logic [STAMP_W-1:0] line_stamp [NUM_LINES];
   logic [31:0]       tick        = '0;
   logic [CNT_W-1:0]  hit_tally   = '0;
   logic [CNT_W-1:0]  miss_tally  = '0;
   logic [CNT_W-1:0]  evict_tally = '0;
   logic [2:0]        set_bits_reg = 3'd1;
   logic [3:0]        ways_reg     = 4'd1;
   logic [4:0]        off_bits_reg = 5'd1;

   outcome_type pending_outcomes [$];
   int       fail_count    = 0;
   int       results_seen  = 0;
   int       items_sent    = 0;
   int       settings_used = 0;
   int       cycle_count   = 0;
   bit       steady        = 1'b0;   // no idling on either side while set

   set_assoc_cache_lru_sim dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock
   initial begin
      forever #4 clock = ~clock;
   end

   // cycle limit
   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // effective geometry after range clamping
   function automatic int unsigned eff_set_bits();
      if (set_bits_reg == 0) return 1;
      if (set_bits_reg > MAX_SET_BITS_DEF) return MAX_SET_BITS_DEF;
      return 32'(set_bits_reg);
   endfunction

   function automatic int unsigned eff_ways();
      if (ways_reg == 0) return 1;
      if (ways_reg > MAX_WAYS_DEF) return MAX_WAYS_DEF;
      return 32'(ways_reg);
   endfunction

   function automatic int unsigned eff_off_bits();
      return (off_bits_reg == 0) ? 32'd1 : 32'(off_bits_reg);
   endfunction

   // one access against the directory; updates lines, clock and totals
   function automatic outcome_type cache_access(logic [KIND_W-1:0] kind,
                                                logic [31:0] addr);
      outcome_type o;
      int unsigned s, e, b, base, pick;
      logic [31:0] tag, set_idx, age, oldest;
      logic        hit, placed;
      o = '0;
      if (kind != KIND_FETCH) begin
         if (kind <= KIND_MODIFY) begin
            s       = eff_set_bits();
            e       = eff_ways();
            b       = eff_off_bits();
            tag     = (s + b >= 32) ? 32'd0 : (addr >> (s + b));
            set_idx = (addr >> b) & ((32'd1 << s) - 32'd1);
            base    = set_idx * NUM_WAYS;
            hit     = 1'b0;
            placed  = 1'b0;
            // tag match
            for (int w = 0; w < e; w++) begin
               if (!hit && line_ok[base+w] && line_tagv[base+w] == tag) begin
                  hit = 1'b1;
                  line_stamp[base+w] = tick;
               end
            end
            // first free way
            if (!hit) begin
               for (int w = 0; w < e; w++) begin
                  if (!placed && !line_ok[base+w]) begin
                     placed = 1'b1;
                     line_ok[base+w]    = 1'b1;
                     line_tagv[base+w]  = tag;
                     line_stamp[base+w] = tick;
                  end
               end
            end
            // oldest way, lowest index on a tie
            if (!hit && !placed) begin
               pick   = 0;
               oldest = tick - line_stamp[base];
               for (int w = 1; w < e; w++) begin
                  age = tick - line_stamp[base+w];
                  if (age > oldest) begin
                     oldest = age;
                     pick   = w;
                  end
               end
               line_tagv[base+pick]  = tag;
               line_stamp[base+pick] = tick;
               o.evict = 1'b1;
            end
            o.hits = hit ? 2'd1 : 2'd0;
            o.miss = !hit;
            if (kind == KIND_MODIFY) o.hits = o.hits + 2'd1;
            hit_tally   = hit_tally + CNT_W'(o.hits);
            miss_tally  = miss_tally + CNT_W'(o.miss);
            evict_tally = evict_tally + CNT_W'(o.evict);
         end
         tick = tick + 32'd1;
      end
      o.hit_sum   = hit_tally;
      o.miss_sum  = miss_tally;
      o.evict_sum = evict_tally;
      return o;
   endfunction

   // address mostly drawn from a small working set of the current split
   function automatic logic [31:0] make_address(logic [31:0] tag_salt);
      int unsigned s, b;
      logic [31:0] tagv, setv, offv;
      s = eff_set_bits();
      b = eff_off_bits();
      if ($urandom_range(99) < 15) return $urandom();
      tagv = tag_salt + $urandom_range(0, eff_ways() + 1);
      setv = ($urandom_range(1) == 0) ? $urandom_range(0, 3) : $urandom();
      setv = setv & ((32'd1 << s) - 32'd1);
      offv = $urandom() & ((32'd1 << b) - 32'd1);
      return ((s + b >= 32) ? 32'd0 : (tagv << (s + b))) | (setv << b) | offv;
   endfunction

   function automatic logic [KIND_W-1:0] pick_kind();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 35) return KIND_LOAD;
      if (r < 60) return KIND_STORE;
      if (r < 82) return KIND_MODIFY;
      if (r < 91) return KIND_FETCH;
      return KIND_W'($urandom_range(KIND_OTHER_LO, KIND_OTHER_HI));
   endfunction

   // register write: setup phase, access phase, then idle with the select dropped
   task automatic reg_write(logic [1:0] idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_SET_BITS: set_bits_reg = value[2:0];
         REG_WAYS:     ways_reg     = value[3:0];
         REG_OFF_BITS: off_bits_reg = value[4:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // hold the access stream until every result has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // one access transfer; valid stays high afterwards for a back-to-back item
   task automatic send_access(logic [KIND_W-1:0] kind, logic [31:0] addr,
                              logic fixed, outcome_type typed);
      outcome_type o;
      while (!steady && $urandom_range(99) < 11) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= addr;
      req_tuser  <= {5'b0, kind};
      do @(posedge clock); while (!req_tready);
      o = cache_access(kind, addr);
      pending_outcomes.push_back(fixed ? typed : o);
      items_sent++;
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   // result side: random stalls, compare each transfer with the oldest entry
   initial begin
      outcome_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (pending_outcomes.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result: expected none, got %h",
                        $time, rsp_tdata);
            end else begin
               want = pending_outcomes.pop_front();
               check_field("hits_added",     32'(want.hits),  32'(rsp_tdata[1:0]));
               check_field("was_miss",       32'(want.miss),  32'(rsp_tdata[2]));
               check_field("was_eviction",   32'(want.evict), 32'(rsp_tdata[3]));
               check_field("hit_total",      want.hit_sum,    rsp_tdata[35:4]);
               check_field("miss_total",     want.miss_sum,   rsp_tdata[67:36]);
               check_field("eviction_total", want.evict_sum,  rsp_tdata[99:68]);
            end
         end
         rsp_tready <= steady || ($urandom_range(99) >= 11);
      end
   end

   // reset, directed table, random phases, end of run
   initial begin
      int          n_phase;
      int          random_sent;
      logic [31:0] tag_salt;
      logic [31:0] set_val, ways_val, off_val;
      for (int i = 0; i < NUM_LINES; i++) begin
         line_ok[i]    = 1'b0;
         line_tagv[i]  = '0;
         line_stamp[i] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part
      foreach (directed_rows[i]) begin
         if (directed_rows[i].op == ROW_REG) begin
            wait_drained();
            reg_write(directed_rows[i].reg_idx, directed_rows[i].value);
            settings_used++;
         end else begin
            send_access(directed_rows[i].kind, directed_rows[i].value,
                        directed_rows[i].fixed, directed_rows[i].result);
         end
      end

      // random phases, each under its own geometry
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         wait_drained();
         case ($urandom_range(4))
            0:       set_val = 0;
            1:       set_val = 7;
            default: set_val = $urandom_range(1, MAX_SET_BITS_DEF);
         endcase
         case ($urandom_range(4))
            0:       ways_val = 0;
            1:       ways_val = 15;
            default: ways_val = $urandom_range(1, MAX_WAYS_DEF);
         endcase
         case ($urandom_range(4))
            0:       off_val = $urandom_range(0, 31);
            default: off_val = $urandom_range(0, 8);
         endcase
         reg_write(REG_SET_BITS, set_val);
         reg_write(REG_WAYS, ways_val);
         reg_write(REG_OFF_BITS, off_val);
         settings_used++;
         tag_salt = ($urandom_range(1) == 0) ? 32'd0 : $urandom();
         n_phase  = $urandom_range(40, 120);
         for (int k = 0; k < n_phase && random_sent < RANDOM_ITEMS; k++) begin
            steady = (random_sent >= 350 && random_sent < 550);
            send_access(pick_kind(), make_address(tag_salt), 1'b0, '0);
            random_sent++;
         end
      end
      steady = 1'b0;

      // drain and finish
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d accesses (%0d directed rows) over %0d register settings,",
               items_sent, NUM_ROWS, settings_used);
      $display("%0d results checked; model totals: %0d hits, %0d misses, %0d evictions",
               results_seen, hit_tally, miss_tally, evict_tally);
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== set_assoc_cache_lru_sim.f =====
sv/sacl_pkg.sv
sv/sacl_csr.sv
sv/sacl_ctrl.sv
sv/sacl_dp.sv
sv/set_assoc_cache_lru_sim.sv
dv/tb_top.sv
